// File: rtl/crmsd_pkg.sv
// ----------------------------------------------------------------------------
// crmsd_pkg
// Shared types and constants of the coordinate RMSD block: beat payloads,
// the job handed from the accumulator to the divide/root engine, and the
// engine's state codes.
// ----------------------------------------------------------------------------
`default_nettype none

package crmsd_pkg;

  // Coordinate and result geometry
  localparam int COORD_W   = 24;
  localparam int MAX_ATOMS = 4096;
  localparam int CNT_W     = 13;
  localparam int SUM_W     = 64;
  localparam int RMSD_W    = 32;

  // Job queue between the accumulator and the divide/root engine
  localparam int JOB_DEPTH = 2;

  // Iteration counts of the engine
  localparam int DIV_STEPS  = SUM_W;
  localparam int ROOT_STEPS = SUM_W / 2;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  typedef struct packed {
    logic signed [COORD_W-1:0] ref_x;
    logic signed [COORD_W-1:0] ref_y;
    logic signed [COORD_W-1:0] ref_z;
    logic signed [COORD_W-1:0] cmp_x;
    logic signed [COORD_W-1:0] cmp_y;
    logic signed [COORD_W-1:0] cmp_z;
    logic                      last_atom;
  } pair_t;

  typedef struct packed {
    logic [RMSD_W-1:0] rmsd;
    logic [CNT_W-1:0]  atoms_used;
    logic              overflow;
  } result_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
    logic             overflow;
  } job_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_DIVIDE,
    ENG_ROOT,
    ENG_HOLD
  } eng_state_t;

endpackage

`default_nettype wire

// File: rtl/crmsd_front.sv
// ----------------------------------------------------------------------------
// crmsd_front
// Front end: accepts atom-pair beats one per cycle unless stalled, counts
// them, squares the coordinate differences in a short pipeline, folds them
// into a saturating sum. The pair marked last closes the set and pushes a job.
// ----------------------------------------------------------------------------
`default_nettype none

module crmsd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                pair_valid,
  output logic                pair_stall,
  input  crmsd_pkg::pair_t    pair,
  input  logic                q_full,
  output logic                push,
  output crmsd_pkg::job_t     job
);
  import crmsd_pkg::*;

  localparam int DIFF_W = COORD_W + 1;
  localparam int SQ_W   = 2 * COORD_W;
  localparam int D2_W   = SQ_W + 2;

  typedef struct packed {
    logic             last;
    logic             skip;
    logic             many;
    logic [CNT_W-1:0] cnt;
  } meta_t;

  // Set bookkeeping at the accept point
  logic [CNT_W-1:0] cnt;
  logic             many;
  logic             take;
  logic             enable;
  logic             at_max;
  meta_t            meta_in;

  // Pipeline stages
  logic             s1_valid, s2_valid, s3_valid;
  meta_t            s1_meta, s2_meta, s3_meta;
  logic [COORD_W-1:0] s1_mx, s1_my, s1_mz;
  logic [SQ_W-1:0]  s2_qx, s2_qy, s2_qz;
  logic [D2_W-1:0]  s3_d2;

  // Accumulator
  logic [SUM_W-1:0] sum;
  logic             sat_seen;
  logic [SUM_W:0]   sum_add;
  logic [SUM_W-1:0] sum_new;
  logic             sat_new;

  // Magnitudes of the differences
  logic signed [DIFF_W-1:0] dx, dy, dz;
  logic [COORD_W-1:0]       mx, my, mz;

  // Stall everything while a closing pair waits for queue room
  assign enable     = !(s3_valid && s3_meta.last && q_full);
  assign pair_stall = !enable;
  assign take       = pair_valid && enable;
  assign at_max     = (cnt == CNT_W'(MAX_ATOMS));

  always_comb begin
    meta_in.last = pair.last_atom;
    meta_in.skip = at_max;
    meta_in.many = many || at_max;
    meta_in.cnt  = at_max ? cnt : cnt + CNT_W'(1);
  end

  always_comb begin
    dx = DIFF_W'(pair.ref_x) - DIFF_W'(pair.cmp_x);
    dy = DIFF_W'(pair.ref_y) - DIFF_W'(pair.cmp_y);
    dz = DIFF_W'(pair.ref_z) - DIFF_W'(pair.cmp_z);
    mx = dx[DIFF_W-1] ? COORD_W'(-dx) : COORD_W'(dx);
    my = dy[DIFF_W-1] ? COORD_W'(-dy) : COORD_W'(dy);
    mz = dz[DIFF_W-1] ? COORD_W'(-dz) : COORD_W'(dz);
  end

  // Count pairs of the open set; clear on the closing beat
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      many <= 1'b0;
    end else if (take) begin
      if (pair.last_atom) begin
        cnt  <= '0;
        many <= 1'b0;
      end else begin
        cnt  <= meta_in.cnt;
        many <= meta_in.many;
      end
    end
  end

  // Advance stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (enable) begin
      s1_valid <= pair_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // Advance stage payloads: magnitudes, squares, distance
  always_ff @(posedge clk) begin
    if (enable) begin
      s1_meta <= meta_in;
      s1_mx   <= mx;
      s1_my   <= my;
      s1_mz   <= mz;
      s2_meta <= s1_meta;
      s2_qx   <= s1_mx * s1_mx;
      s2_qy   <= s1_my * s1_my;
      s2_qz   <= s1_mz * s1_mz;
      s3_meta <= s2_meta;
      s3_d2   <= D2_W'(s2_qx) + D2_W'(s2_qy) + D2_W'(s2_qz);
    end
  end

  // Saturating add of the distance into the running sum
  always_comb begin
    sum_add = (SUM_W + 1)'(sum) + (SUM_W + 1)'(s3_d2);
    if (s3_meta.skip) begin
      sum_new = sum;
      sat_new = sat_seen;
    end else if (sum_add[SUM_W]) begin
      sum_new = '1;
      sat_new = 1'b1;
    end else begin
      sum_new = sum_add[SUM_W-1:0];
      sat_new = sat_seen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum      <= '0;
      sat_seen <= 1'b0;
    end else if (enable && s3_valid) begin
      if (s3_meta.last) begin
        sum      <= '0;
        sat_seen <= 1'b0;
      end else begin
        sum      <= sum_new;
        sat_seen <= sat_new;
      end
    end
  end

  // Hand the closed set to the queue
  assign push         = enable && s3_valid && s3_meta.last;
  assign job.sum      = sum_new;
  assign job.count    = s3_meta.cnt;
  assign job.overflow = sat_new || s3_meta.many;

endmodule

`default_nettype wire

// File: rtl/crmsd_queue.sv
// ----------------------------------------------------------------------------
// crmsd_queue
// Small job queue between the accumulator and the divide/root engine, so
// that each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module crmsd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  crmsd_pkg::job_t   push_job,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output crmsd_pkg::job_t   head
);
  import crmsd_pkg::*;

  localparam int PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
  localparam int OCC_W = $clog2(JOB_DEPTH + 1);

  job_t             slots [JOB_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [OCC_W-1:0] occ;
  logic             do_push, do_pop;

  assign full      = (occ == OCC_W'(JOB_DEPTH));
  assign not_empty = (occ != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = slots[rd_ptr];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Move pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      occ    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        occ <= occ + OCC_W'(1);
      end else if (do_pop && !do_push) begin
        occ <= occ - OCC_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/crmsd_back.sv
// ----------------------------------------------------------------------------
// crmsd_back
// Back end: takes one job at a time, divides the sum by the count one
// quotient bit a cycle, takes the floor square root two radicand bits a
// cycle, and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module crmsd_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_avail,
  input  crmsd_pkg::job_t     job,
  output logic                pop,
  output logic                result_valid,
  input  logic                result_stall,
  output crmsd_pkg::result_t  result
);
  import crmsd_pkg::*;

  localparam int REM_W = RMSD_W + 2;

  eng_state_t        state, state_next;
  logic [STEP_W-1:0] step;
  logic [SUM_W-1:0]  acc;
  logic [REM_W-1:0]  rem;
  logic [RMSD_W-1:0] root;
  logic [CNT_W-1:0]  divisor;
  logic              ovf;
  logic              load_out;
  logic              out_free;

  // One divide step
  logic [CNT_W:0]    div_sh;
  logic              div_ge;
  logic [CNT_W:0]    div_rem;

  // One root step
  logic [REM_W:0]    rt_sh;
  logic [REM_W:0]    rt_trial;
  logic              rt_ge;
  logic [REM_W:0]    rt_rem;

  assign out_free = !result_valid || !result_stall;

  always_comb begin
    div_sh  = {rem[CNT_W-1:0], acc[SUM_W-1]};
    div_ge  = (div_sh >= {1'b0, divisor});
    div_rem = div_ge ? div_sh - {1'b0, divisor} : div_sh;
  end

  always_comb begin
    rt_sh    = {rem[REM_W-2:0], acc[SUM_W-1:SUM_W-2]};
    rt_trial = {1'b0, root, 2'b01};
    rt_ge    = (rt_sh >= rt_trial);
    rt_rem   = rt_ge ? rt_sh - rt_trial : rt_sh;
  end

  // Sequence the engine
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    case (state)
      ENG_IDLE: begin
        if (job_avail) begin
          pop        = 1'b1;
          state_next = ENG_DIVIDE;
        end
      end
      ENG_DIVIDE: begin
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = ENG_ROOT;
        end
      end
      ENG_ROOT: begin
        if (step == STEP_W'(ROOT_STEPS - 1)) begin
          state_next = ENG_HOLD;
        end
      end
      ENG_HOLD: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ENG_IDLE;
        end
      end
      default: state_next = ENG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ENG_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Iterate the shared shift register, remainder and root
  always_ff @(posedge clk) begin
    case (state)
      ENG_IDLE: begin
        acc     <= (job.count == '0) ? '0 : job.sum;
        divisor <= job.count;
        ovf     <= job.overflow;
        rem     <= '0;
        root    <= '0;
        step    <= '0;
      end
      ENG_DIVIDE: begin
        acc <= {acc[SUM_W-2:0], div_ge};
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          rem  <= '0;
          step <= '0;
        end else begin
          rem  <= REM_W'(div_rem);
          step <= step + STEP_W'(1);
        end
      end
      ENG_ROOT: begin
        acc  <= {acc[SUM_W-3:0], 2'b00};
        rem  <= rt_rem[REM_W-1:0];
        root <= {root[RMSD_W-2:0], rt_ge};
        step <= step + STEP_W'(1);
      end
      default: begin
        step <= '0;
      end
    endcase
  end

  // Hold the result until the receiver takes the beat
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.rmsd       <= root;
      result.atoms_used <= divisor;
      result.overflow   <= ovf;
    end
  end

endmodule

`default_nettype wire

// File: rtl/coordinate_rmsd.sv
// ----------------------------------------------------------------------------
// coordinate_rmsd
// Root-mean-square deviation of two streamed 3D structures in Q11.12.
// ----------------------------------------------------------------------------
// Usage:
//   The pair channel carries one atom pair per beat (pair_valid / pair_stall);
//   last_atom closes the set. The result channel (result_valid /
//   result_stall) carries one beat per set: rmsd in Q20.12, atoms_used and
//   overflow. Pairs beyond 4096 in a set are dropped and flag overflow.
//   Throughput: one pair per cycle while the job queue has room. The
//   accumulator pipeline registers the magnitudes, squares and distance
//   before writing the job queue; the back end then loads the job, runs
//   the divide (one quotient bit a cycle) and the square root (two
//   radicand bits a cycle) and loads the output register, which raises
//   result_valid. The back end handles one set at a time, so short sets
//   arriving faster than it finishes them fill the two-entry queue and
//   then pair_stall rises until the engine frees a slot.
//   A stalled result holds its value and blocks the engine from loading the
//   next one; accumulation goes on until the queue fills.
//   Synchronous reset clears the open set, the queue and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module coordinate_rmsd (
  input  logic                clk,
  input  logic                rst,
  input  logic                pair_valid,
  output logic                pair_stall,
  input  crmsd_pkg::pair_t    pair,
  output logic                result_valid,
  input  logic                result_stall,
  output crmsd_pkg::result_t  result
);
  import crmsd_pkg::*;

  logic q_full;
  logic q_push;
  job_t q_in;
  logic q_pop;
  logic q_avail;
  job_t q_head;

  crmsd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pair_valid (pair_valid),
    .pair_stall (pair_stall),
    .pair       (pair),
    .q_full     (q_full),
    .push       (q_push),
    .job        (q_in)
  );

  crmsd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_job  (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_avail),
    .head      (q_head)
  );

  crmsd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job_avail    (q_avail),
    .job          (q_head),
    .pop          (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

// File: rtl/crmsd_checker.sv
// ----------------------------------------------------------------------------
// crmsd_checker
// Port-level checks of the coordinate RMSD block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module crmsd_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                pair_valid,
  input  logic                pair_stall,
  input  crmsd_pkg::pair_t    pair,
  input  logic                result_valid,
  input  logic                result_stall,
  input  crmsd_pkg::result_t  result
);
  import crmsd_pkg::*;

  // A stalled pair beat holds
  a_pair_hold: assert property (@(posedge clk) disable iff (rst)
    pair_valid && pair_stall |=> pair_valid && $stable(pair))
    else $error("pair beat changed while stalled");

  // A stalled result beat holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  // Reset drops any pending result
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // A set always holds between one and the maximum number of pairs
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.atoms_used != '0) &&
                     (result.atoms_used <= CNT_W'(MAX_ATOMS)))
    else $error("atoms_used out of range");

  // The divide and root are iterative, so no result appears right after reset
  a_no_early: assert property (@(posedge clk)
    $rose(result_valid) |-> !$past(rst) && !$past(rst, 2) && !$past(rst, 3))
    else $error("result too soon after reset");

endmodule

bind coordinate_rmsd crmsd_checker u_crmsd_checker (.*);

`default_nettype wire

// File: bench/rmsd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmsd_checker
// Watches the pair and result channels of coordinate_rmsd. Every accepted
// pair beat within the set limit is added to a running sum of squared
// distances. A pair that closes a set turns that sum into a predicted RMSD,
// atom count and overflow flag. Each result beat is checked against the
// oldest prediction.
module rmsd_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                pair_valid,
  input  logic                pair_stall,
  input  crmsd_pkg::pair_t    pair,
  input  logic                result_valid,
  input  logic                result_stall,
  input  crmsd_pkg::result_t  result,
  output int                  errors,
  output int                  pending
);
  import crmsd_pkg::*;

  // Running state of the set being accumulated
  logic [SUM_W-1:0] run_sum;
  int unsigned      run_count;
  logic             run_ovf;
  result_t          due_q[$];

  // Squared Euclidean distance of one pair, in Q.24
  function automatic logic [SUM_W-1:0] pair_dist_sq(pair_t p);
    logic signed [SUM_W-1:0] dx, dy, dz;
    dx = p.ref_x;
    dy = p.ref_y;
    dz = p.ref_z;
    dx = dx - p.cmp_x;
    dy = dy - p.cmp_y;
    dz = dz - p.cmp_z;
    return dx * dx + dy * dy + dz * dz;
  endfunction

  // Floor square root, one root bit at a time from the top
  function automatic logic [RMSD_W-1:0] floor_root(logic [SUM_W-1:0] v);
    logic [RMSD_W-1:0] r;
    logic [SUM_W-1:0]  c;
    r = '0;
    for (int i = RMSD_W - 1; i >= 0; i--) begin
      c = r | (RMSD_W'(1) << i);
      if (c * c <= v) r[i] = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    logic [SUM_W:0] wide;
    logic [SUM_W-1:0] mean;
    result_t        want;
    int             miss;
    miss = 0;
    if (rst) begin
      run_sum = '0;
      run_count = 0;
      run_ovf = 1'b0;
      due_q.delete();
      errors <= 0;
    end else begin
      // Check a result beat against the oldest set
      if (result_valid && !result_stall) begin
        if (due_q.size() == 0) begin
          $display("%0t: result beat with no set pending: rmsd %0d atoms %0d overflow %0b",
                   $time, result.rmsd, result.atoms_used, result.overflow);
          miss++;
        end else begin
          want = due_q.pop_front();
          if (result.rmsd !== want.rmsd) begin
            $display("%0t: rmsd expected %0d, got %0d", $time, want.rmsd, result.rmsd);
            miss++;
          end
          if (result.atoms_used !== want.atoms_used) begin
            $display("%0t: atoms_used expected %0d, got %0d",
                     $time, want.atoms_used, result.atoms_used);
            miss++;
          end
          if (result.overflow !== want.overflow) begin
            $display("%0t: overflow expected %0b, got %0b",
                     $time, want.overflow, result.overflow);
            miss++;
          end
        end
      end

      // Fold an accepted pair; drop it and flag overflow once the set is full
      if (pair_valid && !pair_stall) begin
        if (run_count >= MAX_ATOMS) begin
          run_ovf = 1'b1;
        end else begin
          wide = {1'b0, run_sum} + {1'b0, pair_dist_sq(pair)};
          if (wide[SUM_W]) begin
            run_sum = '1;
            run_ovf = 1'b1;
          end else begin
            run_sum = wide[SUM_W-1:0];
          end
          run_count++;
        end
        // Close the set: predict its result and clear
        if (pair.last_atom) begin
          mean = (run_count != 0) ? run_sum / run_count : SUM_W'(0);
          want.rmsd = floor_root(mean);
          want.atoms_used = CNT_W'(run_count);
          want.overflow = run_ovf;
          due_q.push_back(want);
          run_sum = '0;
          run_count = 0;
          run_ovf = 1'b0;
        end
      end
      errors <= errors + miss;
    end
    pending <= due_q.size();
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams atom pair sets into coordinate_rmsd: directed extremes, then
// random sets of mixed length and spread. The sender works in bursts; the
// receiver stalls on its own changing pattern, with one long hold-off to
// fill the block.
// ----------------------------------------------------------------------------
module testbench;
  import crmsd_pkg::*;

  localparam int RANDOM_PAIRS = 1200;
  localparam int LONG_HOLD    = 800;
  localparam int DRAIN_CYCLES = 150;
  localparam int COORD_LO     = -(1 << (COORD_W - 1));
  localparam int COORD_HI     = (1 << (COORD_W - 1)) - 1;

  typedef enum int {SET_NEAR, SET_WIDE, SET_EDGE} set_style_t;

  logic    clk;
  logic    rst;
  logic    pair_valid;
  logic    pair_stall;
  pair_t   pair;
  logic    result_valid;
  logic    result_stall;
  result_t result;
  int      errors;
  int      pending;
  int      burst_left;
  int      pairs_sent;
  bit      hold_ask;

  coordinate_rmsd dut (
    .clk          (clk),
    .rst          (rst),
    .pair_valid   (pair_valid),
    .pair_stall   (pair_stall),
    .pair         (pair),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  rmsd_checker rmsd_check (
    .clk          (clk),
    .rst          (rst),
    .pair_valid   (pair_valid),
    .pair_stall   (pair_stall),
    .pair         (pair),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .errors       (errors),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Coordinate anywhere in range, biased toward the ends and near zero
  function automatic logic signed [COORD_W-1:0] any_coord();
    case ($urandom_range(0, 5))
      0: return COORD_W'(COORD_LO);
      1: return COORD_W'(COORD_HI);
      2: return COORD_W'(int'($urandom_range(0, 8191)) - 4096);
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // Offset a coordinate by a small random amount; wraps at the range ends
  function automatic logic signed [COORD_W-1:0] nudge(logic signed [COORD_W-1:0] c,
                                                      int spread);
    return c + COORD_W'(int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  function automatic pair_t make_pair(set_style_t style, logic last);
    pair_t p;
    int    spread;
    spread = ($urandom_range(0, 3) == 0) ? 65536 : 64;
    p.ref_x = any_coord();
    p.ref_y = any_coord();
    p.ref_z = any_coord();
    case (style)
      SET_NEAR: begin
        p.cmp_x = nudge(p.ref_x, spread);
        p.cmp_y = nudge(p.ref_y, spread);
        p.cmp_z = nudge(p.ref_z, spread);
      end
      SET_WIDE: begin
        p.cmp_x = any_coord();
        p.cmp_y = any_coord();
        p.cmp_z = any_coord();
      end
      default: begin
        p.ref_x = $urandom_range(0, 1) ? COORD_W'(COORD_HI) : COORD_W'(COORD_LO);
        p.cmp_x = $urandom_range(0, 1) ? COORD_W'(COORD_HI) : COORD_W'(COORD_LO);
        p.cmp_y = $urandom_range(0, 1) ? COORD_W'(COORD_HI) : COORD_W'(COORD_LO);
        p.cmp_z = any_coord();
      end
    endcase
    p.last_atom = last;
    return p;
  endfunction

  function automatic pair_t pair_of(int rx, int ry, int rz, int cx, int cy, int cz,
                                    logic last);
    pair_t p;
    p.ref_x = COORD_W'(rx);
    p.ref_y = COORD_W'(ry);
    p.ref_z = COORD_W'(rz);
    p.cmp_x = COORD_W'(cx);
    p.cmp_y = COORD_W'(cy);
    p.cmp_z = COORD_W'(cz);
    p.last_atom = last;
    return p;
  endfunction

  // Present one beat and hold it until accepted; open a gap between bursts
  task automatic offer(pair_t p);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        pair_valid <= 1'b0;
        pair <= make_pair(SET_WIDE, 1'($urandom_range(0, 1)));
      end
    end
    burst_left--;
    @(negedge clk);
    pair_valid <= 1'b1;
    pair <= p;
    do @(posedge clk); while (pair_stall);
    pairs_sent++;
  endtask

  // Stop offering until every closed set has reported
  task automatic drain_wait();
    @(negedge clk);
    pair_valid <= 1'b0;
    wait (pending == 0);
  endtask

  // Receiver: stall on a pattern that changes every stretch, hold once
  initial begin : result_side
    int mode;
    int span;
    bit held;
    held = 1'b0;
    result_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 160);
      repeat (span) begin
        @(negedge clk);
        if (hold_ask && !held) begin
          held = 1'b1;
          result_stall <= 1'b1;
          repeat (LONG_HOLD) @(negedge clk);
        end
        case (mode)
          0: result_stall <= 1'b0;
          1: result_stall <= ($urandom_range(0, 3) == 0);
          2: result_stall <= ($urandom_range(0, 3) != 0);
          default: result_stall <= ~result_stall;
        endcase
      end
    end
  end

  initial begin : pair_side
    int         mark;
    int         pick;
    int         set_len;
    bit         paused;
    set_style_t style;
    rst = 1'b1;
    pair_valid = 1'b0;
    pair = '0;
    hold_ask = 1'b0;
    burst_left = 0;
    pairs_sent = 0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Single-pair sets at the extremes, zero and one-LSB distances
    offer(pair_of(0, 0, 0, 0, 0, 0, 1'b1));
    offer(pair_of(0, 0, 0, 1, 1, 1, 1'b1));
    offer(pair_of(COORD_LO, COORD_LO, COORD_LO, COORD_HI, COORD_HI, COORD_HI, 1'b1));
    offer(pair_of(COORD_HI, COORD_HI, COORD_HI, COORD_LO, COORD_LO, COORD_LO, 1'b1));
    offer(pair_of(1234, -5678, 91011, 1234, -5678, 91011, 1'b1));
    // Short sets with mixed signs
    offer(pair_of(100, -200, 300, -100, 200, -300, 1'b0));
    offer(pair_of(COORD_HI, 0, COORD_LO, 0, COORD_HI, 0, 1'b0));
    offer(pair_of(-1, -1, -1, 1, 1, 1, 1'b0));
    offer(pair_of(4095, -4096, 0, -4096, 4095, 7, 1'b1));
    offer(pair_of(COORD_LO, COORD_HI, 0, COORD_HI, COORD_LO, 0, 1'b0));
    offer(pair_of(0, 0, 0, 0, 0, 0, 1'b1));
    offer(pair_of(3, 4, 0, 0, 0, 0, 1'b1));
    drain_wait();

    // Random sets, mostly short so the back end stays busy
    hold_ask = 1'b1;
    mark = pairs_sent;
    paused = 1'b0;
    while (pairs_sent - mark < RANDOM_PAIRS) begin
      pick = $urandom_range(0, 99);
      set_len = (pick < 80) ? $urandom_range(1, 6) :
                (pick < 95) ? $urandom_range(7, 40) : $urandom_range(41, 200);
      style = set_style_t'($urandom_range(0, 2));
      for (int k = 1; k <= set_len; k++) offer(make_pair(style, k == set_len));
      if (!paused && pairs_sent - mark >= RANDOM_PAIRS / 2) begin
        drain_wait();
        paused = 1'b1;
      end
    end
    drain_wait();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Give up long after the slowest correct run would have ended
  initial begin : watchdog
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
